/* src/tcfa_pkg.sv */
`default_nettype none
package tcfa_pkg;

	localparam int SMALL_COUNT = 512;
	localparam int LARGE_COUNT = 128;
	localparam int TOTAL_COUNT = SMALL_COUNT + LARGE_COUNT;

	localparam int NUM_W   = 10;
	localparam int BYTES_W = 16;
	localparam int STAT_W  = 2;

	localparam int SIDX_W = (SMALL_COUNT > 1) ? $clog2(SMALL_COUNT) : 1;
	localparam int LIDX_W = (LARGE_COUNT > 1) ? $clog2(LARGE_COUNT) : 1;
	localparam int SCNT_W = $clog2(SMALL_COUNT + 1);
	localparam int LCNT_W = $clog2(LARGE_COUNT + 1);
	localparam int MAP_AW = $clog2(TOTAL_COUNT);

	localparam int HDR_BYTES = 16;
	localparam logic [BYTES_W-1:0] SMALL_BYTES_RST = 16'd128;
	localparam logic [BYTES_W-1:0] LARGE_BYTES_RST = 16'd4096;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 32;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SMALL_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LARGE_BYTES = 2'd1;

	localparam logic FUNC_FETCH = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADNUM = 2'd2;
	localparam logic [STAT_W-1:0] ST_DOUBLE = 2'd3;

	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

/* src/tcfa_ram.sv */
`default_nettype none
module tcfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* src/tcfa_datapath.sv */
`default_nettype none
module tcfa_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire tcfa_pkg::cmd_t                     cmd,
	output tcfa_pkg::stat_t                         stat,
	input  wire logic                               cfg_we,
	input  wire logic [tcfa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tcfa_pkg::BYTES_W-1:0]       cfg_wdata,
	input  wire logic [tcfa_pkg::IN_TDATA_W-1:0]    in_tdata,
	input  wire logic                               in_tuser,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [tcfa_pkg::OUT_TDATA_W-1:0]   out_tdata,
	output logic      [tcfa_pkg::STAT_W-1:0]        out_tuser
);

	localparam int NUM_W   = tcfa_pkg::NUM_W;
	localparam int BYTES_W = tcfa_pkg::BYTES_W;
	localparam int SIDX_W  = tcfa_pkg::SIDX_W;
	localparam int LIDX_W  = tcfa_pkg::LIDX_W;
	localparam int SCNT_W  = tcfa_pkg::SCNT_W;
	localparam int LCNT_W  = tcfa_pkg::LCNT_W;
	localparam int MAP_AW  = tcfa_pkg::MAP_AW;

	logic [BYTES_W-1:0] small_bytes_q, large_bytes_q;
	logic [SCNT_W-1:0]  scnt_q, slw_q;
	logic [LCNT_W-1:0]  lcnt_q, llw_q;
	logic               out_valid_q;
	logic [tcfa_pkg::STAT_W-1:0] out_stat_q;
	logic [NUM_W-1:0]   out_num_q;
	logic [BYTES_W-1:0] out_bytes_q;

	logic               func_q, small_sel_q;
	logic [NUM_W-1:0]   num_q;

	logic [BYTES_W:0]   need_bytes;
	logic [SCNT_W-1:0]  sdec;
	logic [LCNT_W-1:0]  ldec;
	logic [SIDX_W-1:0]  s_rdata, idx_s;
	logic [LIDX_W-1:0]  l_rdata, idx_l;
	logic               map_rdata;
	logic [NUM_W-1:0]   lidx;
	logic               is_small, bad_num, in_use, class_full;
	logic               fetch_ok, free_ok;
	logic [NUM_W-1:0]   res_num;
	logic [BYTES_W-1:0] res_bytes;
	logic [tcfa_pkg::STAT_W-1:0] res_stat;
	logic               map_we, map_wdata;
	logic [NUM_W-1:0]   map_wnum;
	logic               s_we, l_we;

	// Slots below the low-water mark were never popped and still hold their own index.
	assign sdec  = scnt_q - 1'b1;
	assign ldec  = lcnt_q - 1'b1;
	assign idx_s = (scnt_q == slw_q) ? sdec[SIDX_W-1:0] : s_rdata;
	assign idx_l = (lcnt_q == llw_q) ? ldec[LIDX_W-1:0] : l_rdata;

	assign need_bytes = {1'b0, in_tdata[BYTES_W-1:0]} + (BYTES_W+1)'(tcfa_pkg::HDR_BYTES);

	assign lidx     = num_q - NUM_W'(tcfa_pkg::SMALL_COUNT);
	assign is_small = num_q < NUM_W'(tcfa_pkg::SMALL_COUNT);
	assign bad_num  = num_q >= NUM_W'(tcfa_pkg::TOTAL_COUNT);
	// A number never fetched sits below its class's low-water mark: its map bit is unwritten.
	assign in_use   = map_rdata & (is_small ? (num_q >= NUM_W'(slw_q)) : (lidx >= NUM_W'(llw_q)));
	assign class_full = is_small ? (scnt_q >= SCNT_W'(tcfa_pkg::SMALL_COUNT))
	                             : (lcnt_q >= LCNT_W'(tcfa_pkg::LARGE_COUNT));

	always_comb begin
		fetch_ok  = 1'b0;
		free_ok   = 1'b0;
		res_stat  = tcfa_pkg::ST_OK;
		res_num   = num_q;
		res_bytes = '0;
		map_wnum  = num_q;
		map_wdata = 1'b0;
		if (func_q == tcfa_pkg::FUNC_FETCH) begin
			map_wdata = 1'b1;
			if (small_sel_q) begin
				map_wnum = NUM_W'(idx_s);
				if (scnt_q == '0) begin
					res_stat = tcfa_pkg::ST_EMPTY;
					res_num  = '0;
				end else begin
					fetch_ok  = 1'b1;
					res_num   = NUM_W'(idx_s);
					res_bytes = small_bytes_q;
				end
			end else begin
				map_wnum = NUM_W'(tcfa_pkg::SMALL_COUNT) + NUM_W'(idx_l);
				if (lcnt_q == '0) begin
					res_stat = tcfa_pkg::ST_EMPTY;
					res_num  = '0;
				end else begin
					fetch_ok  = 1'b1;
					res_num   = map_wnum;
					res_bytes = large_bytes_q;
				end
			end
		end else begin
			if (bad_num) begin
				res_stat = tcfa_pkg::ST_BADNUM;
			end else if (!in_use || class_full) begin
				res_stat = tcfa_pkg::ST_DOUBLE;
			end else begin
				free_ok   = 1'b1;
				res_bytes = is_small ? small_bytes_q : large_bytes_q;
			end
		end
	end

	assign map_we = cmd.commit & (fetch_ok | free_ok);
	assign s_we   = cmd.commit & free_ok & is_small;
	assign l_we   = cmd.commit & free_ok & ~is_small;

	tcfa_ram #(.WIDTH(SIDX_W), .DEPTH(tcfa_pkg::SMALL_COUNT)) u_small_stack (
		.clk   (clk),
		.we    (s_we),
		.waddr (scnt_q[SIDX_W-1:0]),
		.wdata (num_q[SIDX_W-1:0]),
		.raddr (sdec[SIDX_W-1:0]),
		.rdata (s_rdata)
	);

	tcfa_ram #(.WIDTH(LIDX_W), .DEPTH(tcfa_pkg::LARGE_COUNT)) u_large_stack (
		.clk   (clk),
		.we    (l_we),
		.waddr (lcnt_q[LIDX_W-1:0]),
		.wdata (lidx[LIDX_W-1:0]),
		.raddr (ldec[LIDX_W-1:0]),
		.rdata (l_rdata)
	);

	tcfa_ram #(.WIDTH(1), .DEPTH(tcfa_pkg::TOTAL_COUNT)) u_in_use_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_wnum[MAP_AW-1:0]),
		.wdata (map_wdata),
		.raddr (num_q[MAP_AW-1:0]),
		.rdata (map_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_bytes_q <= tcfa_pkg::SMALL_BYTES_RST;
			large_bytes_q <= tcfa_pkg::LARGE_BYTES_RST;
			scnt_q        <= SCNT_W'(tcfa_pkg::SMALL_COUNT);
			slw_q         <= SCNT_W'(tcfa_pkg::SMALL_COUNT);
			lcnt_q        <= LCNT_W'(tcfa_pkg::LARGE_COUNT);
			llw_q         <= LCNT_W'(tcfa_pkg::LARGE_COUNT);
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == tcfa_pkg::REG_SMALL_BYTES) begin
				small_bytes_q <= cfg_wdata;
			end
			if (cfg_we && cfg_index == tcfa_pkg::REG_LARGE_BYTES) begin
				large_bytes_q <= cfg_wdata;
			end
			// The low-water mark only moves when a pop goes below it.
			if (cmd.commit && fetch_ok && small_sel_q) begin
				scnt_q <= sdec;
				if (scnt_q == slw_q) begin
					slw_q <= sdec;
				end
			end
			if (cmd.commit && fetch_ok && !small_sel_q) begin
				lcnt_q <= ldec;
				if (lcnt_q == llw_q) begin
					llw_q <= ldec;
				end
			end
			if (s_we) begin
				scnt_q <= scnt_q + 1'b1;
			end
			if (l_we) begin
				lcnt_q <= lcnt_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q      <= in_tuser;
			num_q       <= in_tdata[BYTES_W+NUM_W-1:BYTES_W];
			small_sel_q <= need_bytes <= {1'b0, small_bytes_q};
		end
		if (cmd.commit) begin
			out_stat_q  <= res_stat;
			out_num_q   <= res_num;
			out_bytes_q <= res_bytes;
		end
	end

	assign stat.out_free = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;
	assign out_tuser = out_stat_q;
	assign out_tdata = {(tcfa_pkg::OUT_TDATA_W-NUM_W-BYTES_W)'(0), out_bytes_q, out_num_q};

	a_small_lw: assert property (@(posedge clk) disable iff (!arst_n) slw_q <= scnt_q)
		else $error("small count below its low-water mark");
	a_large_lw: assert property (@(posedge clk) disable iff (!arst_n) llw_q <= lcnt_q)
		else $error("large count below its low-water mark");
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n) cmd.commit |=> out_valid_q)
		else $error("commit did not load the output register");

endmodule
`default_nettype wire

/* src/tcfa_ctrl.sv */
`default_nettype none
module tcfa_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire tcfa_pkg::stat_t stat,
	output tcfa_pkg::cmd_t       cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_EVAL = 2'd2;

	logic [1:0] state_q, state_d;

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.load   = in_valid & in_ready;
	// Commit only once the output register can take the result.
	assign cmd.commit = (state_q == S_EVAL) & stat.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.load) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (cmd.commit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_rd: assert property (@(posedge clk) disable iff (!arst_n) cmd.load |=> state_q == S_RD)
		else $error("accepted item did not start a memory read");
	a_rd_eval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |=> state_q == S_EVAL)
		else $error("read state did not advance");
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> in_ready)
		else $error("not ready after commit");

endmodule
`default_nettype wire

/* src/two_class_fragment_allocator.sv */
`default_nettype none
// Fragment allocator with a small and a large class, each a LIFO free stack in RAM. An item
// with tuser 0 fetches a fragment (small class when payload + 16 fits the small size), tuser 1
// frees the fragment number in tdata; every item gives one result with a status in tuser and
// the number and class size in tdata. Each item goes through these steps: the accepting edge
// latches the request, the next edge does the registered read of the stack and in-use RAMs,
// and a later edge commits the push or pop and loads the result, which raises m_axis_tvalid;
// the commit holds while the output register is full and not being drained. A new item is
// accepted at the earliest on the edge after the previous one commits, so none is taken
// while another is in flight. After reset the block is ready at once: no clearing pass runs,
// since low-water marks on each stack tell unwritten entries. The user must write the size
// registers through cfg_we/cfg_index/cfg_wdata only while the block is idle (not enforced).
module two_class_fragment_allocator (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [tcfa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tcfa_pkg::BYTES_W-1:0]       cfg_wdata,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// payload_bytes [15:0], frag_number [25:16], zero [31:26]
	input  wire logic [tcfa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// func [0]
	input  wire logic                               s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// granted_number [9:0], granted_bytes [25:10], zero [31:26]
	output logic      [tcfa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// status [1:0]
	output logic      [tcfa_pkg::STAT_W-1:0]        m_axis_tuser
);

	tcfa_pkg::cmd_t  cmd;
	tcfa_pkg::stat_t stat;

	tcfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcfa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_tdata (m_axis_tdata),
		.out_tuser (m_axis_tuser)
	);

endmodule
`default_nettype wire
